// ===== src/assert_macros.svh =====
// Assertion helpers used by npps_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/npps_pkg.sv =====
package npps_pkg;

  localparam int TIME_W = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } proc_entry_t;

  // One request from the front to the back.
  typedef struct packed {
    logic        wr;
    logic        last;
    proc_entry_t entry;
  } npps_cmd_t;

endpackage

// ===== src/npps_front.sv =====
module npps_front #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        proc_id,
  input  logic [15:0]       arrival,
  input  logic [15:0]       burst,
  input  logic [7:0]        prio,
  input  logic              final_item,
  output logic              push_valid,
  input  logic              push_stall,
  output npps_pkg::npps_cmd_t push_cmd,
  input  logic              run_done
);
  import npps_pkg::*;

  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic          room;
  logic          accept;

  assign room     = cnt < CW'(MAX_PROCS);
  assign in_stall = busy || push_stall;
  assign accept   = in_valid && !in_stall;

  // Drop loads beyond the table size; a final request always goes through.
  assign push_valid        = in_valid && !busy && (room || final_item);
  assign push_cmd.wr       = room;
  assign push_cmd.last     = final_item;
  assign push_cmd.entry.id      = proc_id;
  assign push_cmd.entry.arrival = arrival;
  assign push_cmd.entry.burst   = burst;
  assign push_cmd.entry.prio    = prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else begin
      if (run_done) busy <= 1'b0;
      if (accept) begin
        if (final_item) begin
          cnt  <= '0;
          busy <= 1'b1;
        end else if (room) begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

// ===== src/npps_queue.sv =====
module npps_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_stall,
  input  npps_pkg::npps_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_stall,
  output npps_pkg::npps_cmd_t pop_cmd
);
  import npps_pkg::*;

  npps_cmd_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_stall = fill == QCNT_W'(QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/npps_back.sv =====
module npps_back #(
  parameter int MAX_PROCS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_stall,
  input  npps_pkg::npps_cmd_t q_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          sched_id,
  output logic [20:0]         completion,
  output logic [20:0]         turnaround,
  output logic [20:0]         waiting,
  output logic                run_end,
  output logic                run_done
);
  import npps_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int IW = $clog2(MAX_PROCS);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_COMP,
    ST_TAT,
    ST_EMIT
  } state_t;

  state_t              state;
  proc_entry_t         proc_mem [MAX_PROCS];
  proc_entry_t         rd_data;
  logic [IW-1:0]       rd_idx;
  logic                rd_vld;
  logic [CW-1:0]       scan_addr;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [CW-1:0]       k;
  logic [TIME_W-1:0]   clock_time;
  logic [MAX_PROCS-1:0] done_flags;

  logic                a_vld;
  proc_entry_t         a_ent;
  logic [IW-1:0]       a_idx;
  logic                b_vld;
  proc_entry_t         b_ent;
  logic [IW-1:0]       b_idx;

  proc_entry_t         sel_ent;
  logic [TIME_W-1:0]   comp;
  logic [TIME_W-1:0]   tat;

  logic                q_pop;
  logic                arrived;
  logic                a_take;
  logic                b_take;
  logic [TIME_W-1:0]   start;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   comp_sat;
  logic [TIME_W-1:0]   arr_ext;
  logic [TIME_W-1:0]   burst_ext;
  logic                last_pick;

  assign q_stall  = state != ST_LOAD;
  assign q_pop    = q_valid && !q_stall;
  assign cnt_next = cnt + (q_cmd.wr ? CW'(1) : CW'(0));

  always_comb begin
    arrived = {5'b0, rd_data.arrival} <= clock_time;
    a_take  = rd_vld && !done_flags[rd_idx] && arrived &&
              (!a_vld || rd_data.prio < a_ent.prio);
    // Earliest arrival, then lowest prio value; load order breaks the rest.
    b_take  = rd_vld && !done_flags[rd_idx] &&
              (!b_vld || rd_data.arrival < b_ent.arrival ||
               (rd_data.arrival == b_ent.arrival && rd_data.prio < b_ent.prio));
  end

  // Nothing arrived by the clock: idle up to the earliest pending arrival.
  always_comb begin
    start    = a_vld ? clock_time : {5'b0, b_ent.arrival};
    sum      = {1'b0, start} + {6'b0, (a_vld ? a_ent.burst : b_ent.burst)};
    comp_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  assign arr_ext   = {5'b0, sel_ent.arrival};
  assign burst_ext = {5'b0, sel_ent.burst};
  assign last_pick = (k + CW'(1)) == cnt;

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr) proc_mem[cnt[IW-1:0]] <= q_cmd.entry;
  end

  always_ff @(posedge clk) begin
    rd_data <= proc_mem[scan_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      cnt        <= '0;
      k          <= '0;
      clock_time <= '0;
      done_flags <= '0;
      scan_addr  <= '0;
      rd_vld     <= 1'b0;
      a_vld      <= 1'b0;
      b_vld      <= 1'b0;
      out_valid  <= 1'b0;
      run_done   <= 1'b0;
    end else begin
      run_done <= 1'b0;
      rd_vld   <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (a_take) begin
        a_vld <= 1'b1;
        a_ent <= rd_data;
        a_idx <= rd_idx;
      end
      if (b_take) begin
        b_vld <= 1'b1;
        b_ent <= rd_data;
        b_idx <= rd_idx;
      end
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            cnt <= cnt_next;
            if (q_cmd.last) begin
              if (cnt_next == '0) begin
                run_done <= 1'b1;
              end else begin
                state     <= ST_SCAN;
                scan_addr <= '0;
                a_vld     <= 1'b0;
                b_vld     <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_addr < cnt) begin
            rd_vld    <= 1'b1;
            rd_idx    <= scan_addr[IW-1:0];
            scan_addr <= scan_addr + CW'(1);
          end else if (!rd_vld) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          sel_ent    <= a_vld ? a_ent : b_ent;
          comp       <= comp_sat;
          clock_time <= comp_sat;
          done_flags[a_vld ? a_idx : b_idx] <= 1'b1;
          state      <= ST_TAT;
        end
        ST_TAT: begin
          tat   <= (comp >= arr_ext) ? comp - arr_ext : '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            sched_id   <= sel_ent.id;
            completion <= comp;
            turnaround <= tat;
            waiting    <= (tat >= burst_ext) ? tat - burst_ext : '0;
            run_end    <= last_pick;
            if (last_pick) begin
              cnt        <= '0;
              k          <= '0;
              clock_time <= '0;
              done_flags <= '0;
              run_done   <= 1'b1;
              state      <= ST_LOAD;
            end else begin
              k         <= k + CW'(1);
              scan_addr <= '0;
              a_vld     <= 1'b0;
              b_vld     <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  `ASSERT_IMP(a_pick_in_range, clk, rst, state != ST_LOAD, k < cnt)
  `ASSERT_IMP(a_run_cleared, clk, rst, run_done, done_flags == '0 && cnt == '0)
  `ASSERT_NEXT(a_comp_has_cand, clk, rst, state == ST_SCAN && scan_addr == cnt && !rd_vld,
               a_vld || b_vld)

endmodule

// ===== src/nonpreemptive_priority_scheduler.sv =====
// Channel   Direction  Handshake            Payload
// load      in         in_valid/in_stall    proc_id arrival burst prio final_item
// result    out        out_valid/out_stall  sched_id completion turnaround waiting run_end
//
// Loads take one request a cycle while in_stall is low, through a four-deep queue into the table.
// Each result takes one scan of the N loaded entries in the table memory
// (one registered read port) plus three arithmetic steps.
// Reset is synchronous; it clears counters, done flags and the queue, not the table.
// A stalled result sits in the output register while the next scan runs; loads stall
// from the final request until run_done, registered with the last result, frees the front.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  proc_id,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [7:0]  prio,
  input  logic        final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  sched_id,
  output logic [20:0] completion,
  output logic [20:0] turnaround,
  output logic [20:0] waiting,
  output logic        run_end
);
  import npps_pkg::*;

  logic      push_valid;
  logic      push_stall;
  npps_cmd_t push_cmd;
  logic      q_valid;
  logic      q_stall;
  npps_cmd_t q_cmd;
  logic      run_done;

  npps_front #(.MAX_PROCS(MAX_PROCS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .proc_id    (proc_id),
    .arrival    (arrival),
    .burst      (burst),
    .prio       (prio),
    .final_item (final_item),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd),
    .run_done   (run_done)
  );

  npps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_cmd    (q_cmd)
  );

  npps_back #(.MAX_PROCS(MAX_PROCS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_stall    (q_stall),
    .q_cmd      (q_cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sched_id   (sched_id),
    .completion (completion),
    .turnaround (turnaround),
    .waiting    (waiting),
    .run_end    (run_end),
    .run_done   (run_done)
  );

endmodule

// ===== tb/sv/tb_nonpreemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps

module tb_nonpreemptive_priority_scheduler;
  import npps_pkg::*;

  localparam int MAX_PROCS  = 16;
  localparam int RAND_ITEMS = 245;
  localparam int PHASE_LEN  = 35;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 60;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    proc_entry_t entry;
    logic        last;
  } load_req_t;

  typedef struct packed {
    logic [7:0]        id;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              run_end;
  } sched_rec_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  sched_id;
  logic [20:0] completion;
  logic [20:0] turnaround;
  logic [20:0] waiting;
  logic        run_end;

  load_req_t cur_req = '0;

  load_req_t  load_q[$];
  sched_rec_t sched_expect_q[$];

  // Predictor state for the set being loaded
  proc_entry_t proc_tbl[MAX_PROCS];
  int          set_count = 0;

  int   loads_accepted = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   hold_left = 0;
  bit   hold_used = 1'b0;
  logic [1:0] phase;

  assign phase = 2'((loads_accepted / PHASE_LEN) % 4);

  nonpreemptive_priority_scheduler #(
    .MAX_PROCS(MAX_PROCS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .proc_id   (cur_req.entry.id),
    .arrival   (cur_req.entry.arrival),
    .burst     (cur_req.entry.burst),
    .prio      (cur_req.entry.prio),
    .final_item(cur_req.last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sched_id  (sched_id),
    .completion(completion),
    .turnaround(turnaround),
    .waiting   (waiting),
    .run_end   (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void queue_load(input logic [7:0] id, input logic [15:0] arr,
                                     input logic [15:0] bst, input logic [7:0] pr,
                                     input logic last);
    load_req_t r;
    r.entry.id      = id;
    r.entry.arrival = arr;
    r.entry.burst   = bst;
    r.entry.prio    = pr;
    r.last          = last;
    load_q.push_back(r);
  endfunction

  // Store one process; on the closing request, schedule the set and queue its results.
  task automatic load_process(input load_req_t r);
    bit          done[MAX_PROCS];
    int          best;
    int unsigned now;
    int unsigned earliest;
    int unsigned start;
    int unsigned comp;
    int unsigned tat;
    int unsigned wt;
    bit          any;
    sched_rec_t  rec;
    if (set_count < MAX_PROCS) begin
      proc_tbl[set_count] = r.entry;
      set_count++;
    end
    if (r.last) begin
      foreach (done[i]) done[i] = 1'b0;
      now = 0;
      for (int k = 0; k < set_count; k++) begin
        best = -1;
        if (k == 0) begin
          for (int i = 0; i < set_count; i++) begin
            if (best < 0 || proc_tbl[i].arrival < proc_tbl[best].arrival ||
                (proc_tbl[i].arrival == proc_tbl[best].arrival &&
                 proc_tbl[i].prio < proc_tbl[best].prio))
              best = i;
          end
          start = 32'(proc_tbl[best].arrival);
        end else begin
          // Idle until the earliest pending arrival if nothing has arrived yet
          any = 1'b0;
          earliest = 0;
          for (int i = 0; i < set_count; i++) begin
            if (!done[i]) begin
              if (!any || proc_tbl[i].arrival < earliest)
                earliest = 32'(proc_tbl[i].arrival);
              any = 1'b1;
            end
          end
          if (earliest > now) now = earliest;
          for (int i = 0; i < set_count; i++) begin
            if (!done[i] && proc_tbl[i].arrival <= now &&
                (best < 0 || proc_tbl[i].prio < proc_tbl[best].prio))
              best = i;
          end
          start = now;
        end
        comp = start + proc_tbl[best].burst;
        if (comp > TIME_MAX) comp = TIME_MAX;
        now = comp;
        done[best] = 1'b1;
        tat = (comp >= proc_tbl[best].arrival) ? comp - proc_tbl[best].arrival : 0;
        wt  = (tat >= proc_tbl[best].burst) ? tat - proc_tbl[best].burst : 0;
        rec.id         = proc_tbl[best].id;
        rec.completion = comp[TIME_W-1:0];
        rec.turnaround = tat[TIME_W-1:0];
        rec.waiting    = wt[TIME_W-1:0];
        rec.run_end    = (k + 1 == set_count);
        sched_expect_q.push_back(rec);
      end
      set_count = 0;
    end
  endtask

  // Load driver
  always @(posedge clk) begin
    int  idle_pct;
    bit  go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        load_process(cur_req);
        loads_accepted <= loads_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        case (phase)
          2'd1:    idle_pct = 54;
          2'd3:    idle_pct = 19;
          default: idle_pct = 0;
        endcase
        go = (load_q.size() != 0) && ($urandom_range(99) >= idle_pct);
        if (go) begin
          cur_req <= load_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so the load side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && loads_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    int         stall_pct;
    sched_rec_t exp_rec;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sched_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: id=%0d comp=%0d tat=%0d wait=%0d end=%0b",
                     sched_id, completion, turnaround, waiting, run_end);
        end else begin
          exp_rec = sched_expect_q.pop_front();
          if (sched_id !== exp_rec.id || completion !== exp_rec.completion ||
              turnaround !== exp_rec.turnaround || waiting !== exp_rec.waiting ||
              run_end !== exp_rec.run_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp id=%0d comp=%0d tat=%0d wait=%0d end=%0b,",
                     exp_rec.id, exp_rec.completion, exp_rec.turnaround,
                     exp_rec.waiting, exp_rec.run_end);
              $display(" got id=%0d comp=%0d tat=%0d wait=%0d end=%0b",
                       sched_id, completion, turnaround, waiting, run_end);
            end
          end
        end
      end
      case (phase)
        2'd2:    stall_pct = 54;
        2'd3:    stall_pct = 19;
        default: stall_pct = 0;
      endcase
      out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
    end
  end

  // Cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int         n_rand;
    int         set_len;
    int         sel;
    int         amode;
    bit         wide_burst;
    bit         narrow_prio;
    logic [15:0] base;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0]  pr;
    bit         timed_out;

    // Single process, all fields low, then all fields high
    queue_load(8'd0, 16'd0, 16'd0, 8'd0, 1'b1);
    queue_load(8'hff, 16'hffff, 16'hffff, 8'hff, 1'b1);
    // Arrival ties broken by prio then position, later prio ties by position, idle gap
    queue_load(8'd10, 16'd5, 16'd3, 8'd7, 1'b0);
    queue_load(8'd11, 16'd5, 16'd4, 8'd2, 1'b0);
    queue_load(8'd12, 16'd5, 16'd2, 8'd2, 1'b0);
    queue_load(8'd14, 16'd6, 16'd1, 8'd2, 1'b0);
    queue_load(8'd13, 16'd100, 16'd1, 8'd0, 1'b1);
    // Full table: the closing request is dropped but still starts the run
    for (int i = 0; i < MAX_PROCS + 1; i++)
      queue_load(8'(i + 32), 16'((MAX_PROCS - i) * 3), 16'(i), 8'(i % 3),
                 i == MAX_PROCS);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 65)      set_len = $urandom_range(6, 1);
      else if (sel < 90) set_len = $urandom_range(16, 7);
      else               set_len = $urandom_range(19, 17);
      amode       = $urandom_range(3);
      wide_burst  = 1'($urandom_range(1));
      narrow_prio = ($urandom_range(2) != 0);
      base        = 16'($urandom_range(65535));
      for (int j = 0; j < set_len; j++) begin
        case (amode)
          0:       arr = 16'($urandom_range(40));
          1:       arr = 16'($urandom_range(65535));
          2:       arr = base;
          default: arr = 16'($urandom_range(65535, 65500));
        endcase
        bst = wide_burst ? 16'($urandom_range(65535)) : 16'($urandom_range(30));
        pr  = narrow_prio ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        queue_load(8'($urandom_range(255)), arr, bst, pr, j == set_len - 1);
      end
      n_rand += set_len;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    timed_out = 1'b0;
    while ((load_q.size() != 0 || in_valid || sched_expect_q.size() != 0) && !timed_out) begin
      @(posedge clk);
      timed_out = (idle_cycles >= IDLE_LIMIT);
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (timed_out || sched_expect_q.size() != 0)
      $display("tb_nonpreemptive_priority_scheduler failed");
    else if (mismatches == 0)
      $display("tb_nonpreemptive_priority_scheduler passed");
    else
      $display("tb_nonpreemptive_priority_scheduler failed");
    $finish;
  end

endmodule
